// ----- hdl/assert_macros.svh -----
// Assertion helper macros for the selective-repeat sender window.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while the active-low reset is asserted
`define SRSW_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset
`define SRSW_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/srsw_pkg.sv -----
// Shared constants, types and helpers of the selective-repeat sender window.
// No dependencies; imported by the slot RAM user and the top level.
`timescale 1ns / 1ps

package srsw_pkg;

    localparam int PACKET_BYTES = 1024;
    localparam int SEQ_LIMIT    = 32768;
    localparam int WINDOW_MAX   = 16;

    localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);

    // result kinds
    localparam logic [1:0] KIND_NEW  = 2'd0;
    localparam logic [1:0] KIND_RTX  = 2'd1;
    localparam logic [1:0] KIND_FIN  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_WINDOW  = 2'd0;
    localparam logic [1:0] CFG_FILE    = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT = 2'd2;

    // one window slot as held in the slot RAM
    typedef struct packed {
        logic [14:0] seq;
        logic [10:0] bytes;
        logic [7:0]  wrap;
        logic [23:0] offset;
        logic [15:0] timer;
    } slot_t;

    // ring position of the entry pos places behind the head
    function automatic logic [SLOT_W-1:0] slot_at(input logic [SLOT_W-1:0] head,
                                                  input logic [CNT_W-1:0] pos);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(head) + (CNT_W+1)'(pos);
        if (sum >= (CNT_W+1)'(WINDOW_MAX)) begin
            sum = sum - (CNT_W+1)'(WINDOW_MAX);
        end
        return sum[SLOT_W-1:0];
    endfunction

endpackage

// ----- hdl/srsw_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; holds the window slots of the sender.
`timescale 1ns / 1ps

module srsw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/selective_repeat_sender_window.sv -----
// Selective-repeat sender window: top level with sequencer and result register.
// Depends on srsw_pkg, srsw_ram and assert_macros.svh.
//
// One input beat is a tick (s_tuser = 0) or an ACK (s_tuser = 1). Each beat
// first issues the next data packet when the window has room and file data
// remains, then walks the in-flight entries in the slot RAM, each in a read
// state and then a modify-and-write-back state, aging timers on a tick or
// looking for the matching entry on an ACK; an acked head then slides the
// window one entry per cycle. Results (at most three per beat) leave through
// the result register and may be stalled by m_tready; a new beat is accepted
// only in idle, after the last beat's results are all loaded for output.
// The read-modify-write loop through the single slot RAM paces the walk.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module selective_repeat_sender_window (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_wdata,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // ack_seq[15:0], ack_wrap[23:16]
    input  logic        s_tuser,   // command
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // seq_num[14:0], byte_count[25:15],
                                   // wrap_count[33:26], file_offset[57:34], zero
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast    // last
);
    import srsw_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ISSUE = 3'd1;
    localparam logic [2:0] ST_RD    = 3'd2;
    localparam logic [2:0] ST_MOD   = 3'd3;
    localparam logic [2:0] ST_SLIDE = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    // configuration
    logic [4:0]  window_reg;
    logic [23:0] file_reg;
    logic [15:0] timeout_reg;

    // control and window state
    logic [2:0]            state_reg, state_next;
    logic                  cmd_reg, cmd_next;
    logic [15:0]           ack_seq_reg, ack_seq_next;
    logic [7:0]            ack_wrap_reg, ack_wrap_next;
    logic [WINDOW_MAX-1:0] acked_reg, acked_next;
    logic [SLOT_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]      inflight_reg, inflight_next;
    logic [14:0]           next_seq_reg, next_seq_next;
    logic [7:0]            wraps_reg, wraps_next;
    logic [23:0]           send_off_reg, send_off_next;
    logic [14:0]           acked_total_reg, acked_total_next;
    logic                  fin_done_reg, fin_done_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [SLOT_W-1:0]     cur_slot_reg, cur_slot_next;
    logic                  found_reg, found_next;
    logic                  pend_new_reg, pend_new_next;
    logic                  pend_rtx_reg, pend_rtx_next;
    logic                  pend_fin_reg, pend_fin_next;
    slot_t                 new_data_reg, new_data_next;
    slot_t                 rtx_data_reg, rtx_data_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_kind_reg, out_kind_next;
    slot_t       out_data_reg, out_data_next;
    logic        out_last_reg, out_last_next;

    // slot RAM port
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    slot_t             mem_wdata;
    logic [SLOT_W-1:0] rd_addr;
    slot_t             rd_data;

    srsw_ram #(
        .WIDTH($bits(slot_t)),
        .DEPTH(WINDOW_MAX),
        .AW   (SLOT_W)
    ) u_slots (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    assign rd_addr = slot_at(head_reg, idx_reg);

    // issue decision
    logic [7:0]        lim_ext;
    logic              can_issue;
    logic [23:0]       left;
    logic [10:0]       cnt;
    logic [15:0]       seq_sum;
    logic [SLOT_W-1:0] issue_slot;

    always_comb begin
        lim_ext = (8'(window_reg) > 8'(WINDOW_MAX)) ? 8'(WINDOW_MAX) : 8'(window_reg);
        can_issue = (8'(inflight_reg) < lim_ext) && (send_off_reg < file_reg);
        left = file_reg - send_off_reg;
        cnt = (left < 24'(PACKET_BYTES)) ? left[10:0] : 11'(PACKET_BYTES);
        seq_sum = {1'b0, next_seq_reg} + 16'(cnt);
        issue_slot = slot_at(head_reg, inflight_reg);
    end

    // per-entry update terms
    logic [15:0] timer_inc;
    logic        expired;
    logic        ack_match;

    always_comb begin
        timer_inc = (rd_data.timer == 16'hFFFF) ? rd_data.timer : rd_data.timer + 16'd1;
        expired = timer_inc >= timeout_reg;
        ack_match = ((16'(rd_data.seq) + 16'(rd_data.bytes)) == ack_seq_reg) &&
                    (rd_data.wrap == ack_wrap_reg);
    end

    // sequencer
    always_comb begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        ack_seq_next     = ack_seq_reg;
        ack_wrap_next    = ack_wrap_reg;
        acked_next       = acked_reg;
        head_next        = head_reg;
        inflight_next    = inflight_reg;
        next_seq_next    = next_seq_reg;
        wraps_next       = wraps_reg;
        send_off_next    = send_off_reg;
        acked_total_next = acked_total_reg;
        fin_done_next    = fin_done_reg;
        idx_next         = idx_reg;
        cur_slot_next    = cur_slot_reg;
        found_next       = found_reg;
        pend_new_next    = pend_new_reg;
        pend_rtx_next    = pend_rtx_reg;
        pend_fin_next    = pend_fin_reg;
        new_data_next    = new_data_reg;
        rtx_data_next    = rtx_data_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_kind_next    = out_kind_reg;
        out_data_next    = out_data_reg;
        out_last_next    = out_last_reg;
        mem_we           = 1'b0;
        mem_waddr        = cur_slot_reg;
        mem_wdata        = rd_data;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next      = s_tuser;
                    ack_seq_next  = s_tdata[15:0];
                    ack_wrap_next = s_tdata[23:16];
                    state_next    = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (can_issue) begin
                    mem_we              = 1'b1;
                    mem_waddr           = issue_slot;
                    mem_wdata.seq       = next_seq_reg;
                    mem_wdata.bytes     = cnt;
                    mem_wdata.wrap      = wraps_reg;
                    mem_wdata.offset    = send_off_reg;
                    mem_wdata.timer     = 16'd0;
                    new_data_next       = mem_wdata;
                    acked_next[issue_slot] = 1'b0;
                    inflight_next       = inflight_reg + CNT_W'(1);
                    send_off_next       = send_off_reg + 24'(cnt);
                    if (seq_sum >= 16'(SEQ_LIMIT)) begin
                        next_seq_next = 15'(seq_sum - 16'(SEQ_LIMIT));
                        wraps_next    = wraps_reg + 8'd1;
                    end else begin
                        next_seq_next = seq_sum[14:0];
                    end
                    pend_new_next = 1'b1;
                end
                idx_next   = '0;
                found_next = 1'b0;
                state_next = ST_RD;
            end
            ST_RD: begin
                if (idx_reg == inflight_reg) begin
                    state_next = ST_FIN;
                end else begin
                    cur_slot_next = rd_addr;
                    state_next    = ST_MOD;
                end
            end
            ST_MOD: begin
                state_next = ST_RD;
                idx_next   = idx_reg + CNT_W'(1);
                if (!cmd_reg) begin
                    // tick: age unacked entries, retransmit the first expired one
                    if (!acked_reg[cur_slot_reg]) begin
                        mem_we = 1'b1;
                        if (!found_reg && expired) begin
                            mem_wdata.timer = 16'd0;
                            rtx_data_next   = mem_wdata;
                            found_next      = 1'b1;
                            pend_rtx_next   = 1'b1;
                        end else begin
                            mem_wdata.timer = timer_inc;
                        end
                    end
                end else if (ack_match) begin
                    // ack: first match decides, later entries are not looked at
                    if (idx_reg == '0) begin
                        acked_next[cur_slot_reg] = 1'b1;
                        state_next = ST_SLIDE;
                    end else begin
                        state_next = ST_FIN;
                    end
                    if (idx_reg == '0 || !acked_reg[cur_slot_reg]) begin
                        acked_next[cur_slot_reg] = 1'b1;
                        if (acked_total_reg != 15'h7FFF) begin
                            acked_total_next = acked_total_reg + 15'd1;
                        end
                    end
                end
            end
            ST_SLIDE: begin
                if (inflight_reg != '0 && acked_reg[head_reg]) begin
                    acked_next[head_reg] = 1'b0;
                    head_next     = slot_at(head_reg, CNT_W'(1));
                    inflight_next = inflight_reg - CNT_W'(1);
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!fin_done_reg && inflight_reg == '0 && send_off_reg >= file_reg) begin
                    fin_done_next = 1'b1;
                    pend_fin_next = 1'b1;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                // results leave in order: new data, retransmission, FIN
                if (!(pend_new_reg || pend_rtx_reg || pend_fin_reg)) begin
                    state_next = ST_IDLE;
                end else if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    priority if (pend_new_reg) begin
                        out_kind_next = KIND_NEW;
                        out_data_next = new_data_reg;
                        out_last_next = !(pend_rtx_reg || pend_fin_reg);
                        pend_new_next = 1'b0;
                    end else if (pend_rtx_reg) begin
                        out_kind_next = KIND_RTX;
                        out_data_next = rtx_data_reg;
                        out_last_next = !pend_fin_reg;
                        pend_rtx_next = 1'b0;
                    end else begin
                        out_kind_next = KIND_FIN;
                        out_data_next = '0;
                        out_last_next = 1'b1;
                        pend_fin_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            acked_reg       <= '0;
            head_reg        <= '0;
            inflight_reg    <= '0;
            next_seq_reg    <= '0;
            wraps_reg       <= '0;
            send_off_reg    <= '0;
            acked_total_reg <= '0;
            fin_done_reg    <= 1'b0;
            found_reg       <= 1'b0;
            pend_new_reg    <= 1'b0;
            pend_rtx_reg    <= 1'b0;
            pend_fin_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            acked_reg       <= acked_next;
            head_reg        <= head_next;
            inflight_reg    <= inflight_next;
            next_seq_reg    <= next_seq_next;
            wraps_reg       <= wraps_next;
            send_off_reg    <= send_off_next;
            acked_total_reg <= acked_total_next;
            fin_done_reg    <= fin_done_next;
            found_reg       <= found_next;
            pend_new_reg    <= pend_new_next;
            pend_rtx_reg    <= pend_rtx_next;
            pend_fin_reg    <= pend_fin_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        ack_seq_reg  <= ack_seq_next;
        ack_wrap_reg <= ack_wrap_next;
        idx_reg      <= idx_next;
        cur_slot_reg <= cur_slot_next;
        new_data_reg <= new_data_next;
        rtx_data_reg <= rtx_data_next;
        out_kind_reg <= out_kind_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg  <= 5'd4;
            file_reg    <= 24'd1;
            timeout_reg <= 16'd500;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_WINDOW:  window_reg  <= cfg_wdata[4:0];
                CFG_FILE:    file_reg    <= cfg_wdata;
                CFG_TIMEOUT: timeout_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // ports
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'd0, out_data_reg.offset, out_data_reg.wrap,
                       out_data_reg.bytes, out_data_reg.seq};

    // checks
    `SRSW_ASSERT(a_inflight_bound, aclk, aresetn,
                 inflight_reg <= CNT_W'(WINDOW_MAX), "in-flight count beyond window size")
    `SRSW_ASSERT(a_idle_clean, aclk, aresetn,
                 (state_reg == ST_IDLE) |-> !(pend_new_reg || pend_rtx_reg || pend_fin_reg),
                 "idle with results still pending")
    `SRSW_ASSERT(a_fin_empty, aclk, aresetn,
                 $rose(fin_done_reg) |-> (inflight_reg == '0), "FIN raised with packets in flight")

endmodule
